// ===== hw/rtl/gda_pkg.sv =====
// Shared types, constants and calendar helper functions for the date arithmetic core.
package gda_pkg;

	localparam logic [14:0] YEAR_BIAS   = 15'd3200;
	localparam logic [22:0] ERA_DAYS    = 23'd146097;
	localparam logic [8:0]  DAYS_LEAP   = 9'd366;
	localparam logic [8:0]  DAYS_COMMON = 9'd365;
	localparam logic [12:0] Q100_MUL    = 13'd5243;
	localparam logic [3:0]  LAST_MP     = 4'd11;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_A_BAD = 2'd1;
	localparam logic [1:0] STS_B_BAD = 2'd2;
	localparam logic [1:0] STS_RANGE = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_PREP,
		ST_A_CHECK,
		ST_A_SERIAL,
		ST_B_PREP,
		ST_B_CHECK,
		ST_B_SERIAL,
		ST_ADD,
		ST_ERA,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH,
		ST_DIFF,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PREP,
		CMD_CHECK,
		CMD_SERIAL,
		CMD_ADD,
		CMD_ERA,
		CMD_YEAR,
		CMD_MONTH,
		CMD_FINISH,
		CMD_DIFF
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic sel_b;
	} ctrl_t;

	typedef struct packed {
		logic req_type;
		logic valid;
		logic era_ge;
		logic year_ge;
		logic month_ge;
	} stat_t;

	// Exact floor(x / 100) for x below 32768 whose quotient fits in eight bits.
	function automatic logic [7:0] q100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(Q100_MUL);
		return p[26:19];
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Days before a month, counting from March as month index zero.
	function automatic logic [8:0] cum_days(input logic [3:0] mp);
		logic [8:0] c;
		case (mp)
			4'd0: c = 9'd0;
			4'd1: c = 9'd31;
			4'd2: c = 9'd61;
			4'd3: c = 9'd92;
			4'd4: c = 9'd122;
			4'd5: c = 9'd153;
			4'd6: c = 9'd184;
			4'd7: c = 9'd214;
			4'd8: c = 9'd245;
			4'd9: c = 9'd275;
			4'd10: c = 9'd306;
			4'd11: c = 9'd337;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] mp_of_month(input logic [3:0] m);
		return (m >= 4'd3) ? 4'(m - 4'd3) : 4'(m + 4'd9);
	endfunction

endpackage

// ===== hw/rtl/gregorian_date_arithmetic_core.sv =====
// Top level of the Gregorian date arithmetic core: controller and datapath.
//
// A request is taken at a rising clock edge where start is high and busy is low.
// req_type 0 adds offset_days to date A; req_type 1 gives the days from date B
// to date A. The result is on res_year, res_month, res_day, diff_days and
// status when done is high; done is high for exactly one cycle and cannot be held off.
// Invalid dates give status 1 (date A) or 2 (date B); an added date whose year
// leaves 0..MAX_YEAR gives status 3. Unused result fields read zero.
// An invalid date A ends a request once it is checked, and an invalid date B once
// it is checked in turn. A difference converts both dates to day serials and
// subtracts them. An add converts date A, adds offset_days, then steps the day
// count down by 400-year eras, then by years, and then steps through the months.
// One request is in flight at a time; busy stays high from the accepting edge
// through the done cycle, and the next request can be taken in the cycle after.
// Reset returns the controller to idle with busy and done low; a request in
// progress is dropped.
module gregorian_date_arithmetic_core #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               req_type,
	input  logic [13:0]        year_a,
	input  logic [3:0]         month_a,
	input  logic [4:0]         day_a,
	input  logic signed [20:0] offset_days,
	input  logic [13:0]        year_b,
	input  logic [3:0]         month_b,
	input  logic [4:0]         day_b,
	output logic [13:0]        res_year,
	output logic [3:0]         res_month,
	output logic [4:0]         res_day,
	output logic signed [22:0] diff_days,
	output logic [1:0]         status
);

	gda_pkg::ctrl_t ctrl;
	gda_pkg::stat_t stat;

	gda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	gda_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.req_type    (req_type),
		.year_a      (year_a),
		.month_a     (month_a),
		.day_a       (day_a),
		.offset_days (offset_days),
		.year_b      (year_b),
		.month_b     (month_b),
		.day_b       (day_b),
		.res_year    (res_year),
		.res_month   (res_month),
		.res_day     (res_day),
		.diff_days   (diff_days),
		.status      (status)
	);

endmodule

// ===== hw/rtl/gda_ctrl.sv =====
// Controller state machine that sequences the date arithmetic datapath.
module gda_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gda_pkg::stat_t  stat,
	output gda_pkg::ctrl_t  ctrl,
	output logic            busy,
	output logic            done
);

	gda_pkg::state_t state_q;
	gda_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gda_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				if (start) begin
					state_next = gda_pkg::ST_A_PREP;
				end
			end
			gda_pkg::ST_A_PREP: state_next = gda_pkg::ST_A_CHECK;
			gda_pkg::ST_A_CHECK: begin
				state_next = stat.valid ? gda_pkg::ST_A_SERIAL : gda_pkg::ST_DONE;
			end
			gda_pkg::ST_A_SERIAL: begin
				state_next = stat.req_type ? gda_pkg::ST_B_PREP : gda_pkg::ST_ADD;
			end
			gda_pkg::ST_B_PREP: state_next = gda_pkg::ST_B_CHECK;
			gda_pkg::ST_B_CHECK: begin
				state_next = stat.valid ? gda_pkg::ST_B_SERIAL : gda_pkg::ST_DONE;
			end
			gda_pkg::ST_B_SERIAL: state_next = gda_pkg::ST_DIFF;
			gda_pkg::ST_ADD: state_next = gda_pkg::ST_ERA;
			gda_pkg::ST_ERA: begin
				state_next = stat.era_ge ? gda_pkg::ST_ERA : gda_pkg::ST_YEAR;
			end
			gda_pkg::ST_YEAR: begin
				state_next = stat.year_ge ? gda_pkg::ST_YEAR : gda_pkg::ST_MONTH;
			end
			gda_pkg::ST_MONTH: begin
				state_next = stat.month_ge ? gda_pkg::ST_MONTH : gda_pkg::ST_FINISH;
			end
			gda_pkg::ST_FINISH: state_next = gda_pkg::ST_DONE;
			gda_pkg::ST_DIFF: state_next = gda_pkg::ST_DONE;
			gda_pkg::ST_DONE: state_next = gda_pkg::ST_IDLE;
			default: state_next = gda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.cmd   = gda_pkg::CMD_NONE;
		ctrl.sel_b = 1'b0;
		busy       = 1'b1;
		done       = 1'b0;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.cmd = gda_pkg::CMD_LOAD;
				end
			end
			gda_pkg::ST_A_PREP: ctrl.cmd = gda_pkg::CMD_PREP;
			gda_pkg::ST_A_CHECK: ctrl.cmd = gda_pkg::CMD_CHECK;
			gda_pkg::ST_A_SERIAL: ctrl.cmd = gda_pkg::CMD_SERIAL;
			gda_pkg::ST_B_PREP: begin
				ctrl.cmd   = gda_pkg::CMD_PREP;
				ctrl.sel_b = 1'b1;
			end
			gda_pkg::ST_B_CHECK: begin
				ctrl.cmd   = gda_pkg::CMD_CHECK;
				ctrl.sel_b = 1'b1;
			end
			gda_pkg::ST_B_SERIAL: begin
				ctrl.cmd   = gda_pkg::CMD_SERIAL;
				ctrl.sel_b = 1'b1;
			end
			gda_pkg::ST_ADD: ctrl.cmd = gda_pkg::CMD_ADD;
			gda_pkg::ST_ERA: ctrl.cmd = gda_pkg::CMD_ERA;
			gda_pkg::ST_YEAR: ctrl.cmd = gda_pkg::CMD_YEAR;
			gda_pkg::ST_MONTH: ctrl.cmd = gda_pkg::CMD_MONTH;
			gda_pkg::ST_FINISH: ctrl.cmd = gda_pkg::CMD_FINISH;
			gda_pkg::ST_DIFF: ctrl.cmd = gda_pkg::CMD_DIFF;
			gda_pkg::ST_DONE: done = 1'b1;
			default: ctrl.cmd = gda_pkg::CMD_NONE;
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe lasted more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not make the core busy");

	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("core not ready after delivering a result");

endmodule

// ===== hw/rtl/gda_datapath.sv =====
// Datapath with serial day conversion, era, year and month stepping, and result registers.
module gda_datapath #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gda_pkg::ctrl_t     ctrl,
	output gda_pkg::stat_t     stat,
	input  logic               req_type,
	input  logic [13:0]        year_a,
	input  logic [3:0]         month_a,
	input  logic [4:0]         day_a,
	input  logic signed [20:0] offset_days,
	input  logic [13:0]        year_b,
	input  logic [3:0]         month_b,
	input  logic [4:0]         day_b,
	output logic [13:0]        res_year,
	output logic [3:0]         res_month,
	output logic [4:0]         res_day,
	output logic signed [22:0] diff_days,
	output logic [1:0]         status
);

	logic               req_type_q;
	logic [13:0]        ya_q;
	logic [3:0]         ma_q;
	logic [4:0]         da_q;
	logic signed [20:0] off_q;
	logic [13:0]        yb_q;
	logic [3:0]         mb_q;
	logic [4:0]         db_q;

	logic [7:0]  yq_q;
	logic [14:0] yy_q;
	logic [7:0]  yyq_q;
	logic [8:0]  doy_q;
	logic [22:0] sa_q;
	logic [22:0] sb_q;
	logic [22:0] z_q;
	logic [5:0]  era_q;
	logic [8:0]  yoe_q;
	logic [3:0]  mp_q;

	logic [13:0]        res_year_q;
	logic [3:0]         res_month_q;
	logic [4:0]         res_day_q;
	logic signed [22:0] diff_days_q;
	logic [1:0]         status_q;

	logic [13:0] y_sel;
	logic [3:0]  m_sel;
	logic [4:0]  d_sel;
	logic [14:0] y_hund;
	logic        r_zero;
	logic        leap_sel;
	logic [4:0]  mlen_sel;
	logic        valid_sel;
	logic [23:0] serial;
	logic [23:0] z_sum;
	logic [8:0]  yoe_next;
	logic        leap_era;
	logic [8:0]  ylen;
	logic [3:0]  mp_next;
	logic [4:0]  fin_day;
	logic [3:0]  fin_month;
	logic [16:0] fin_year_full;
	logic [16:0] fin_year;
	logic        fin_range_bad;
	logic [23:0] dv;
	logic [22:0] dv_sat;

	assign y_sel = ctrl.sel_b ? yb_q : ya_q;
	assign m_sel = ctrl.sel_b ? mb_q : ma_q;
	assign d_sel = ctrl.sel_b ? db_q : da_q;

	// The leap year test reuses the quotient by 100 registered in the prepare step.
	assign y_hund   = 15'(yq_q) * 15'd100;
	assign r_zero   = ({1'b0, y_sel} == y_hund);
	assign leap_sel = ((y_sel[1:0] == 2'b00) && !r_zero) || (r_zero && (yq_q[1:0] == 2'b00));
	assign mlen_sel = gda_pkg::month_len(m_sel, leap_sel);
	assign valid_sel = (m_sel >= 4'd1) && (m_sel <= 4'd12)
		&& (17'(y_sel) <= 17'(MAX_YEAR))
		&& (d_sel != 5'd0) && (d_sel <= mlen_sel);

	assign serial = 24'(yy_q) * 24'(gda_pkg::DAYS_COMMON) + 24'(yy_q >> 2)
		- 24'(yyq_q) + 24'(yyq_q >> 2) + 24'(doy_q);

	assign z_sum = {1'b0, sa_q} + {{3{off_q[20]}}, off_q};

	// The year of era index n runs from March of n to February of n + 1.
	assign yoe_next = yoe_q + 9'd1;
	assign leap_era = (yoe_next[1:0] == 2'b00) && (yoe_next != 9'd100)
		&& (yoe_next != 9'd200) && (yoe_next != 9'd300);
	assign ylen = leap_era ? gda_pkg::DAYS_LEAP : gda_pkg::DAYS_COMMON;
	assign mp_next = mp_q + 4'd1;

	assign fin_day   = 5'(z_q[8:0] - gda_pkg::cum_days(mp_q) + 9'd1);
	assign fin_month = (mp_q < 4'd10) ? 4'(mp_q + 4'd3) : 4'(mp_q - 4'd9);
	assign fin_year_full = 17'(era_q) * 17'd400 + 17'(yoe_q) + 17'(fin_month <= 4'd2);
	assign fin_year = fin_year_full - 17'(gda_pkg::YEAR_BIAS);
	assign fin_range_bad = (fin_year_full < 17'(gda_pkg::YEAR_BIAS))
		|| (fin_year > 17'(MAX_YEAR));

	assign dv = {1'b0, sa_q} - {1'b0, sb_q};
	assign dv_sat = (dv[23] != dv[22]) ? (dv[23] ? 23'h400000 : 23'h3FFFFF) : dv[22:0];

	assign stat.req_type = req_type_q;
	assign stat.valid    = valid_sel;
	assign stat.era_ge   = (z_q >= gda_pkg::ERA_DAYS);
	assign stat.year_ge  = (z_q >= 23'(ylen));
	assign stat.month_ge = (mp_q < gda_pkg::LAST_MP) && (z_q >= 23'(gda_pkg::cum_days(mp_next)));

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			gda_pkg::CMD_LOAD: begin
				req_type_q <= req_type;
				ya_q       <= year_a;
				ma_q       <= month_a;
				da_q       <= day_a;
				off_q      <= offset_days;
				yb_q       <= year_b;
				mb_q       <= month_b;
				db_q       <= day_b;
			end
			gda_pkg::CMD_PREP: begin
				yq_q  <= gda_pkg::q100({1'b0, y_sel});
				yy_q  <= 15'(y_sel) + gda_pkg::YEAR_BIAS - 15'(m_sel <= 4'd2);
				doy_q <= gda_pkg::cum_days(gda_pkg::mp_of_month(m_sel)) + 9'(d_sel) - 9'd1;
			end
			gda_pkg::CMD_CHECK: begin
				yyq_q <= gda_pkg::q100(yy_q);
				if (!valid_sel) begin
					res_year_q  <= '0;
					res_month_q <= '0;
					res_day_q   <= '0;
					diff_days_q <= '0;
					status_q    <= ctrl.sel_b ? gda_pkg::STS_B_BAD : gda_pkg::STS_A_BAD;
				end
			end
			gda_pkg::CMD_SERIAL: begin
				if (ctrl.sel_b) begin
					sb_q <= serial[22:0];
				end else begin
					sa_q <= serial[22:0];
				end
			end
			gda_pkg::CMD_ADD: begin
				z_q   <= z_sum[22:0];
				era_q <= '0;
				yoe_q <= '0;
				mp_q  <= '0;
			end
			gda_pkg::CMD_ERA: begin
				if (stat.era_ge) begin
					z_q   <= z_q - gda_pkg::ERA_DAYS;
					era_q <= era_q + 6'd1;
				end
			end
			gda_pkg::CMD_YEAR: begin
				if (stat.year_ge) begin
					z_q   <= z_q - 23'(ylen);
					yoe_q <= yoe_next;
				end
			end
			gda_pkg::CMD_MONTH: begin
				if (stat.month_ge) begin
					mp_q <= mp_next;
				end
			end
			gda_pkg::CMD_FINISH: begin
				diff_days_q <= '0;
				if (fin_range_bad) begin
					res_year_q  <= '0;
					res_month_q <= '0;
					res_day_q   <= '0;
					status_q    <= gda_pkg::STS_RANGE;
				end else begin
					res_year_q  <= fin_year[13:0];
					res_month_q <= fin_month;
					res_day_q   <= fin_day;
					status_q    <= gda_pkg::STS_OK;
				end
			end
			gda_pkg::CMD_DIFF: begin
				res_year_q  <= '0;
				res_month_q <= '0;
				res_day_q   <= '0;
				diff_days_q <= dv_sat;
				status_q    <= gda_pkg::STS_OK;
			end
			default: begin
			end
		endcase
	end

	assign res_year  = res_year_q;
	assign res_month = res_month_q;
	assign res_day   = res_day_q;
	assign diff_days = diff_days_q;
	assign status    = status_q;

	a_year_in_era: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == gda_pkg::CMD_YEAR) |-> (z_q < gda_pkg::ERA_DAYS))
		else $error("year stepping started outside one era");

	a_month_in_year: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == gda_pkg::CMD_MONTH) |-> (z_q < 23'(gda_pkg::DAYS_LEAP)))
		else $error("month stepping started outside one year");

endmodule

// ===== tb/sv/gregorian_date_arithmetic_core_test.sv =====
// Self-checking testbench for the Gregorian date arithmetic core: add and difference requests.
module gregorian_date_arithmetic_core_test;

	localparam int MAX_YEAR = 9999;
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_DIFF = 1'b1;
	localparam longint CAL_SHIFT = 3200;
	localparam longint ERA_LEN = 146097;
	localparam int RANDOM_REQUESTS = 700;
	localparam int DRAIN_CYCLES = 500;
	localparam int WATCHDOG_CYCLES = 4000;

	typedef struct {
		logic req_type;
		logic [13:0] year_a;
		logic [3:0] month_a;
		logic [4:0] day_a;
		logic signed [20:0] offset;
		logic [13:0] year_b;
		logic [3:0] month_b;
		logic [4:0] day_b;
		bit wait_idle;
	} date_req_t;

	typedef struct {
		logic [13:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic signed [22:0] diff;
		logic [1:0] status;
		int seq;
	} date_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic req_type = 1'b0;
	logic [13:0] year_a = '0;
	logic [3:0] month_a = 4'd1;
	logic [4:0] day_a = 5'd1;
	logic signed [20:0] offset_days = '0;
	logic [13:0] year_b = '0;
	logic [3:0] month_b = 4'd1;
	logic [4:0] day_b = 5'd1;
	logic busy;
	logic done;
	logic [13:0] res_year;
	logic [3:0] res_month;
	logic [4:0] res_day;
	logic signed [22:0] diff_days;
	logic [1:0] status;

	date_req_t pending[$];
	date_res_t due_results[$];
	logic req_taken = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int requests_taken = 0;
	int results_checked = 0;
	int adds_taken = 0;
	int mismatches = 0;
	int status_hits[4] = '{0, 0, 0, 0};

	gregorian_date_arithmetic_core #(.MAX_YEAR(MAX_YEAR)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.req_type(req_type),
		.year_a(year_a),
		.month_a(month_a),
		.day_a(day_a),
		.offset_days(offset_days),
		.year_b(year_b),
		.month_b(month_b),
		.day_b(day_b),
		.res_year(res_year),
		.res_month(res_month),
		.res_day(res_day),
		.diff_days(diff_days),
		.status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_leap(longint y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic longint days_in_month(longint y, longint m);
		if (m == 2)
			return is_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic bit date_ok(longint y, longint m, longint d);
		return m >= 1 && m <= 12 && y <= MAX_YEAR && d >= 1 && d <= days_in_month(y, m);
	endfunction

	function automatic longint day_number(longint y, longint m, longint d);
		longint yy, era, yoe, doy;
		yy = y + CAL_SHIFT - ((m <= 2) ? 1 : 0);
		era = yy / 400;
		yoe = yy - era * 400;
		doy = (153 * ((m + 9) % 12) + 2) / 5 + d - 1;
		return era * ERA_LEN + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic void civil_date(input longint z, output longint y, output longint m,
			output longint d);
		longint era, doe, yoe, doy, mp;
		era = z / ERA_LEN;
		doe = z - era * ERA_LEN;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		m = (mp < 10) ? mp + 3 : mp - 9;
		d = doy - (153 * mp + 2) / 5 + 1;
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic date_res_t compute_date_result(date_req_t r);
		date_res_t res;
		longint ya, ma, da, yb, mb, db, s, y, m, d, dv;
		ya = r.year_a;
		ma = r.month_a;
		da = r.day_a;
		yb = r.year_b;
		mb = r.month_b;
		db = r.day_b;
		res.year = '0;
		res.month = '0;
		res.day = '0;
		res.diff = '0;
		res.status = gda_pkg::STS_OK;
		res.seq = 0;
		if (!date_ok(ya, ma, da)) begin
			res.status = gda_pkg::STS_A_BAD;
		end else if (r.req_type == REQ_ADD) begin
			s = day_number(ya, ma, da) + longint'(r.offset);
			if (s < 0) begin
				res.status = gda_pkg::STS_RANGE;
			end else begin
				civil_date(s, y, m, d);
				if (y < CAL_SHIFT || y - CAL_SHIFT > MAX_YEAR) begin
					res.status = gda_pkg::STS_RANGE;
				end else begin
					res.year = 14'(y - CAL_SHIFT);
					res.month = 4'(m);
					res.day = 5'(d);
				end
			end
		end else if (!date_ok(yb, mb, db)) begin
			res.status = gda_pkg::STS_B_BAD;
		end else begin
			dv = day_number(ya, ma, da) - day_number(yb, mb, db);
			if (dv > 4194303)
				dv = 4194303;
			if (dv < -4194304)
				dv = -4194304;
			res.diff = 23'(dv);
		end
		return res;
	endfunction

	task automatic queue_request(input logic kind, input int ya, input int ma, input int da,
			input int off, input int yb, input int mb, input int db);
		date_req_t r;
		r.req_type = kind;
		r.year_a = 14'(ya);
		r.month_a = 4'(ma);
		r.day_a = 5'(da);
		r.offset = 21'(off);
		r.year_b = 14'(yb);
		r.month_b = 4'(mb);
		r.day_b = 5'(db);
		r.wait_idle = 1'b0;
		pending.push_back(r);
	endtask

	function automatic void pick_valid_date(output logic [13:0] y, output logic [3:0] m,
			output logic [4:0] d);
		int yy, mm, len;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 9))
					0: yy = 0;
					1: yy = 1;
					2: yy = 4;
					3: yy = 99;
					4: yy = 100;
					5: yy = 400;
					6: yy = 1900;
					7: yy = 2000;
					8: yy = 9998;
					default: yy = MAX_YEAR;
				endcase
			end
			default: yy = $urandom_range(0, MAX_YEAR);
		endcase
		mm = $urandom_range(1, 12);
		len = int'(days_in_month(yy, mm));
		y = 14'(yy);
		m = 4'(mm);
		d = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
	endfunction

	function automatic date_req_t random_request();
		date_req_t r;
		logic [13:0] y;
		logic [3:0] m;
		logic [4:0] d;
		int k;
		r.wait_idle = 1'b0;
		r.req_type = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 15) begin
			r.year_a = 14'($urandom);
			r.month_a = 4'($urandom);
			r.day_a = 5'($urandom);
			r.offset = 21'($urandom);
			r.year_b = 14'($urandom);
			r.month_b = 4'($urandom);
			r.day_b = 5'($urandom);
		end else begin
			pick_valid_date(y, m, d);
			r.year_a = y;
			r.month_a = m;
			r.day_a = d;
			pick_valid_date(y, m, d);
			r.year_b = y;
			r.month_b = m;
			r.day_b = d;
			if ($urandom_range(0, 9) == 0) begin
				r.year_b = r.year_a;
				r.month_b = r.month_a;
				r.day_b = r.day_a;
			end
			case ($urandom_range(0, 3))
				0: k = $urandom_range(0, 62) - 31;
				1: k = $urandom_range(0, 1600) - 800;
				2: k = $urandom_range(0, 80000) - 40000;
				default: k = int'($signed(21'($urandom)));
			endcase
			r.offset = 21'(k);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	always @(negedge clk) begin
		date_req_t r;
		bit go;
		if (arst_n && !(start && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				go = 1'b0;
			end else if (pending.size() == 0) begin
				go = 1'b0;
			end else if (pending[0].wait_idle && (due_results.size() != 0 || busy)) begin
				go = 1'b0;
			end else begin
				go = 1'b1;
			end
			if (go) begin
				r = pending.pop_front();
				req_type <= r.req_type;
				year_a <= r.year_a;
				month_a <= r.month_a;
				day_a <= r.day_a;
				offset_days <= r.offset;
				year_b <= r.year_b;
				month_b <= r.month_b;
				day_b <= r.day_b;
				start <= 1'b1;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		date_req_t asked;
		date_res_t want;
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					report_mismatch("result strobe with no request outstanding");
				end else begin
					want = due_results.pop_front();
					results_checked++;
					if (res_year !== want.year)
						report_mismatch($sformatf("request %0d: res_year %0d, expected %0d",
							want.seq, res_year, want.year));
					if (res_month !== want.month)
						report_mismatch($sformatf("request %0d: res_month %0d, expected %0d",
							want.seq, res_month, want.month));
					if (res_day !== want.day)
						report_mismatch($sformatf("request %0d: res_day %0d, expected %0d",
							want.seq, res_day, want.day));
					if (diff_days !== want.diff)
						report_mismatch($sformatf("request %0d: diff_days %0d, expected %0d",
							want.seq, diff_days, want.diff));
					if (status !== want.status)
						report_mismatch($sformatf("request %0d: status %0d, expected %0d",
							want.seq, status, want.status));
				end
			end
			if (start && !busy) begin
				asked.req_type = req_type;
				asked.year_a = year_a;
				asked.month_a = month_a;
				asked.day_a = day_a;
				asked.offset = offset_days;
				asked.year_b = year_b;
				asked.month_b = month_b;
				asked.day_b = day_b;
				asked.wait_idle = 1'b0;
				want = compute_date_result(asked);
				want.seq = requests_taken;
				due_results.push_back(want);
				requests_taken++;
				if (req_type == REQ_ADD)
					adds_taken++;
				status_hits[want.status]++;
			end
			req_taken <= start && !busy;
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("Timeout: no request or result for %0d cycles.", WATCHDOG_CYCLES);
				$display("** gregorian_date_arithmetic_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		date_req_t r;
		queue_request(REQ_ADD, 2000, 2, 28, 1, 0, 1, 1);
		queue_request(REQ_ADD, 1900, 2, 28, 1, 0, 1, 1);
		queue_request(REQ_ADD, 0, 1, 1, 0, 0, 1, 1);
		queue_request(REQ_ADD, 0, 1, 1, -1, 0, 1, 1);
		queue_request(REQ_ADD, 9999, 12, 31, 1, 0, 1, 1);
		queue_request(REQ_ADD, 9999, 12, 31, -1048576, 0, 1, 1);
		queue_request(REQ_ADD, 0, 3, 1, 1048575, 0, 1, 1);
		queue_request(REQ_ADD, 0, 2, 29, 0, 0, 1, 1);
		queue_request(REQ_ADD, 2024, 12, 31, 1, 0, 1, 1);
		queue_request(REQ_ADD, 2023, 0, 10, 5, 0, 1, 1);
		queue_request(REQ_ADD, 2023, 13, 10, 5, 0, 1, 1);
		queue_request(REQ_ADD, 16383, 15, 31, 5, 0, 1, 1);
		queue_request(REQ_ADD, 2023, 5, 0, 5, 0, 1, 1);
		queue_request(REQ_ADD, 2023, 4, 31, 5, 0, 1, 1);
		queue_request(REQ_ADD, 2023, 2, 29, 5, 0, 1, 1);
		queue_request(REQ_ADD, 10000, 1, 1, 5, 0, 1, 1);
		queue_request(REQ_ADD, 2023, 6, 15, 7, 16383, 15, 0);
		queue_request(REQ_DIFF, 9999, 12, 31, 0, 0, 1, 1);
		queue_request(REQ_DIFF, 0, 1, 1, 0, 9999, 12, 31);
		queue_request(REQ_DIFF, 1970, 1, 1, 0, 1970, 1, 1);
		queue_request(REQ_DIFF, 2000, 3, 1, 0, 2000, 2, 28);
		queue_request(REQ_DIFF, 2000, 3, 1, 0, 2000, 13, 1);
		queue_request(REQ_DIFF, 2000, 3, 1, 0, 2000, 6, 31);
		queue_request(REQ_DIFF, 2000, 3, 1, 0, 10000, 1, 1);
		queue_request(REQ_DIFF, 2100, 2, 29, 0, 2000, 0, 1);
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			r = random_request();
			r.wait_idle = (i == 0) || ($urandom_range(0, 59) == 0);
			pending.push_back(r);
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results: %0d date additions and %0d day differences.",
			results_checked, adds_taken, requests_taken - adds_taken);
		$display("Status mix: ok %0d, bad date A %0d, bad date B %0d, year out of range %0d.",
			status_hits[gda_pkg::STS_OK], status_hits[gda_pkg::STS_A_BAD],
			status_hits[gda_pkg::STS_B_BAD], status_hits[gda_pkg::STS_RANGE]);
		if (mismatches == 0) begin
			$display("** gregorian_date_arithmetic_core: PASSED **");
		end else begin
			$display("** gregorian_date_arithmetic_core: FAILED **");
		end
		$finish;
	end

endmodule
